/* hdl/urx_pkg.sv */
// ============================================================================
// urx_pkg
// Shared types and constants for the UART receiver with ring buffer.
// ============================================================================
package urx_pkg;

	localparam logic [15:0] BIT_PERIOD_RESET = 16'd868;
	localparam int          APB_ADDR_W       = 3;
	localparam int          APB_DATA_W       = 32;
	localparam int          READ_DATA_W      = 8;
	localparam int          COUNT_OUT_W      = 7;

	// register index (byte address / 4)
	localparam logic REG_BIT_PERIOD = 1'b0;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_START,
		FR_DATA,
		FR_STOP
	} urx_front_state_t;

	// front -> back command flags
	typedef struct packed {
		logic pop;
		logic done;
	} urx_cmd_t;

	// result status flags
	typedef struct packed {
		logic read_valid;
		logic byte_done;
		logic overflow;
	} urx_status_t;

endpackage

/* hdl/urx_in_if.sv */
// ============================================================================
// urx_in_if
// Input channel: one sampled line level and pop request per item.
// ============================================================================
interface urx_in_if;
	logic valid;
	logic ready;
	logic line_level;
	logic pop_request;

	modport source (output valid, output line_level, output pop_request, input ready);
	modport sink   (input valid, input line_level, input pop_request, output ready);
endinterface

/* hdl/urx_out_if.sv */
// ============================================================================
// urx_out_if
// Output channel: one result item per input item.
// ============================================================================
interface urx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       read_valid;
	logic       byte_done;
	logic       overflow;
	logic [6:0] stored_count;

	modport source (
		output valid, output read_data, output read_valid, output byte_done,
		output overflow, output stored_count, input ready
	);
	modport sink (
		input valid, input read_data, input read_valid, input byte_done,
		input overflow, input stored_count, output ready
	);
endinterface

/* hdl/urx_ram.sv */
// ============================================================================
// urx_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module urx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read-before-write on a shared address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/urx_front.sv */
// ============================================================================
// urx_front
// Receive framing: edge detect, bit timing, mid-bit sampling, shift in.
// ============================================================================
module urx_front #(
	parameter int DATA_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	urx_in_if.sink              in_ch,
	input  logic [15:0]         bit_period,
	input  logic                q_full,
	output logic                push,
	output urx_pkg::urx_cmd_t   cmd,
	output logic [DATA_BITS-1:0] data
);

	localparam int BC_W = $clog2(DATA_BITS);

	urx_pkg::urx_front_state_t state_q, state_nx;
	logic                 prev_line_q;
	logic [15:0]          tick_q;
	logic [BC_W-1:0]      bcnt_q;
	logic [DATA_BITS-1:0] shift_q;

	logic        accept;
	logic [15:0] target_raw, target;
	logic        tick_hit, last_bit, fall;
	logic        sample, frame_done;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;

	// start bit waits half a period to reach mid-bit
	assign target_raw = (state_q == urx_pkg::FR_START) ? {1'b0, bit_period[15:1]} : bit_period;
	assign target     = (target_raw == 16'd0) ? 16'd1 : target_raw;
	assign tick_hit   = ({1'b0, tick_q} + 17'd1) >= {1'b0, target};
	assign last_bit   = (bcnt_q == BC_W'(DATA_BITS - 1));
	assign fall       = prev_line_q && !in_ch.line_level;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			urx_pkg::FR_IDLE: begin
				if (fall) state_nx = urx_pkg::FR_START;
			end
			urx_pkg::FR_START: begin
				if (tick_hit) state_nx = urx_pkg::FR_DATA;
			end
			urx_pkg::FR_DATA: begin
				if (tick_hit && last_bit) state_nx = urx_pkg::FR_STOP;
			end
			urx_pkg::FR_STOP: begin
				if (tick_hit) state_nx = urx_pkg::FR_IDLE;
			end
			default: state_nx = urx_pkg::FR_IDLE;
		endcase
	end

	always_comb begin
		sample     = 1'b0;
		frame_done = 1'b0;
		unique case (state_q)
			urx_pkg::FR_DATA: sample     = tick_hit;
			urx_pkg::FR_STOP: frame_done = tick_hit;
			default: begin
				sample     = 1'b0;
				frame_done = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= urx_pkg::FR_IDLE;
			prev_line_q <= 1'b1;
			tick_q      <= '0;
			bcnt_q      <= '0;
		end else if (accept) begin
			state_q     <= state_nx;
			prev_line_q <= in_ch.line_level;
			if (state_q == urx_pkg::FR_IDLE || tick_hit) begin
				tick_q <= '0;
			end else begin
				tick_q <= tick_q + 16'd1;
			end
			if (state_q != urx_pkg::FR_DATA) begin
				bcnt_q <= '0;
			end else if (sample) begin
				bcnt_q <= bcnt_q + BC_W'(1);
			end
		end
	end

	// LSB first: after DATA_BITS shifts the first sample sits at bit 0
	always_ff @(posedge clk) begin
		if (accept && sample) begin
			shift_q <= {in_ch.line_level, shift_q[DATA_BITS-1:1]};
		end
	end

	assign push     = accept;
	assign cmd.pop  = in_ch.pop_request;
	assign cmd.done = frame_done;
	assign data     = shift_q;

endmodule

/* hdl/urx_cmdq.sv */
// ============================================================================
// urx_cmdq
// Two-entry command queue between front and back.
// ============================================================================
module urx_cmdq #(
	parameter int WIDTH = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign valid    = (cnt_q != 2'd0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("push into full command queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("pop from empty command queue");

endmodule

/* hdl/urx_back.sv */
// ============================================================================
// urx_back
// Ring-buffer FIFO: serves pops, stores bytes, builds the result item.
// ============================================================================
module urx_back #(
	parameter int BUFFER_DEPTH = 64,
	parameter int DATA_BITS    = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  urx_pkg::urx_cmd_t    cmd,
	input  logic [DATA_BITS-1:0] cmd_data,
	output logic                 cmd_take,
	urx_out_if.source            out_ch
);

	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam int RD_W  = urx_pkg::READ_DATA_W;
	localparam int CO_W  = urx_pkg::COUNT_OUT_W;

	logic [PTR_W-1:0]     wp_q, rp_q;
	logic [CNT_W-1:0]     cnt_q, cnt_pop;
	logic                 adv, pop_ok, wr_ok, full_after;
	logic                 valid_s2;
	urx_pkg::urx_status_t st_s2;
	logic [CNT_W-1:0]     cnt_s2;
	logic [DATA_BITS-1:0] ram_rd;
	logic [RD_W-1:0]      rd8;
	logic [CO_W-1:0]      cnt7;

	// one command per cycle while the output slot is free or draining
	assign adv      = cmd_valid && (!valid_s2 || out_ch.ready);
	assign cmd_take = adv;

	assign pop_ok     = cmd.pop && (cnt_q != '0);
	assign cnt_pop    = cnt_q - CNT_W'(pop_ok);
	assign full_after = (cnt_pop == CNT_W'(BUFFER_DEPTH));
	assign wr_ok      = cmd.done && !full_after;

	urx_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (BUFFER_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (adv && wr_ok),
		.waddr (wp_q),
		.wdata (cmd_data),
		.re    (adv && pop_ok),
		.raddr (rp_q),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				valid_s2 <= 1'b1;
				cnt_q    <= cnt_pop + CNT_W'(wr_ok);
				if (pop_ok) begin
					rp_q <= (rp_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
				end
				if (wr_ok) begin
					wp_q <= (wp_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
				end
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s2.read_valid <= pop_ok;
			st_s2.byte_done  <= cmd.done;
			st_s2.overflow   <= cmd.done && full_after;
			cnt_s2           <= cnt_pop + CNT_W'(wr_ok);
		end
	end

	generate
		if (DATA_BITS >= RD_W) begin : g_rd_trunc
			assign rd8 = ram_rd[RD_W-1:0];
		end else begin : g_rd_ext
			assign rd8 = {{(RD_W - DATA_BITS){1'b0}}, ram_rd};
		end
		if (CNT_W >= CO_W) begin : g_cnt_trunc
			assign cnt7 = cnt_s2[CO_W-1:0];
		end else begin : g_cnt_ext
			assign cnt7 = {{(CO_W - CNT_W){1'b0}}, cnt_s2};
		end
	endgenerate

	assign out_ch.valid        = valid_s2;
	assign out_ch.read_data    = st_s2.read_valid ? rd8 : '0;
	assign out_ch.read_valid   = st_s2.read_valid;
	assign out_ch.byte_done    = st_s2.byte_done;
	assign out_ch.overflow     = st_s2.overflow;
	assign out_ch.stored_count = cnt7;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BUFFER_DEPTH)) else $error("byte count above depth");
	a_ovf_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && st_s2.overflow) |-> st_s2.byte_done) else $error("overflow without frame");
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd.pop && cnt_q == '0) |=> !st_s2.read_valid)
		else $error("pop on empty buffer returned data");
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd.done && !cmd.pop && cnt_q == CNT_W'(BUFFER_DEPTH)) |=>
		(st_s2.overflow && cnt_q == CNT_W'(BUFFER_DEPTH)))
		else $error("byte stored into full buffer");

endmodule

/* hdl/uart_rx_with_ring_buffer.sv */
// ============================================================================
// uart_rx_with_ring_buffer
// 8N1 UART receiver, mid-bit sampling, with a ring-buffer byte FIFO.
// ============================================================================
// Usage:
//   in_ch  : one item per system clock tick, carrying the sampled rx line
//            (line_level) and a pop request. Ready drops only when the
//            two-entry command queue is full, i.e. while out_ch stalls.
//   out_ch : exactly one result item per input item: popped byte and
//            read_valid, byte_done / overflow for a frame ending on that
//            tick, and stored_count after the tick.
//   APB    : register 0 (addr 0) = bit_period_ticks, reset 868. Write only
//            while the block is idle; pready is tied high.
// Timing: an item accepted on in_ch is written into the queue; the back end
//   takes it from there and registers its result (FIFO update plus
//   registered RAM read), and that registered result is offered on out_ch.
//   Sustained rate is 1 item per cycle while out_ch.ready stays high, set by
//   the FIFO update in the back end and the single RAM read port.
// Reset: arst_n clears the framer to idle (line assumed high), empties the
//   queue and the FIFO. Buffer contents are not cleared; only counted
//   entries are ever read.
// Stall: if out_ch.ready stays low, the held result blocks the back end and
//   in_ch.ready drops once the queue holds two items, at most two items
//   after the first refused result; nothing is lost or repeated.
// ============================================================================
module uart_rx_with_ring_buffer #(
	parameter int BUFFER_DEPTH = 64,
	parameter int DATA_BITS    = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [urx_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [urx_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [urx_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	urx_in_if.sink                            in_ch,
	urx_out_if.source                         out_ch
);

	localparam int CMD_W = $bits(urx_pkg::urx_cmd_t);
	localparam int Q_W   = CMD_W + DATA_BITS;

	logic [15:0]          bit_period_q;
	logic                 reg_hit;

	// front -> queue
	logic                 f_push;
	urx_pkg::urx_cmd_t    f_cmd;
	logic [DATA_BITS-1:0] f_data;
	logic                 q_full;

	// queue -> back
	logic                 q_valid, q_take;
	logic [Q_W-1:0]       q_data;
	urx_pkg::urx_cmd_t    b_cmd;
	logic [DATA_BITS-1:0] b_data;

	// ---------------- configuration ----------------
	assign pready  = 1'b1;
	assign reg_hit = (paddr[urx_pkg::APB_ADDR_W-1:2] == urx_pkg::REG_BIT_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= urx_pkg::BIT_PERIOD_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			bit_period_q <= pwdata[15:0];
		end
	end

	assign prdata = reg_hit ? {16'd0, bit_period_q} : '0;

	// ---------------- front: framing ----------------
	urx_front #(
		.DATA_BITS (DATA_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.bit_period (bit_period_q),
		.q_full     (q_full),
		.push       (f_push),
		.cmd        (f_cmd),
		.data       (f_data)
	);

	// ---------------- decoupling queue ----------------
	urx_cmdq #(
		.WIDTH (Q_W)
	) u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_data, f_cmd}),
		.full      (q_full),
		.pop       (q_take),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	assign b_cmd  = q_data[CMD_W-1:0];
	assign b_data = q_data[Q_W-1:CMD_W];

	// ---------------- back: FIFO and result ----------------
	urx_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.DATA_BITS    (DATA_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (b_cmd),
		.cmd_data  (b_data),
		.cmd_take  (q_take),
		.out_ch    (out_ch)
	);

endmodule
